// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge out of reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true at a rising clock edge out of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- sv/lfu_pkg.sv -----
// ---------------------------------------------------------------------------
// LFU frame replacement package
// Sizes, reset values and sequencer states for the replacement unit.
// ---------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned FRAMES    = 16;
  localparam int unsigned PAGE_BITS = 16;
  localparam int unsigned SLOT_W    = $clog2(FRAMES);
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned FAULT_W   = 16;
  localparam int unsigned PORT_SLOT_W = 4;
  localparam int unsigned PORT_PAGE_W = 16;

  localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = CFG_W'(16);
  localparam logic [CFG_W-1:0] CFG_FRAMES_MAX   = CFG_W'(FRAMES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

endpackage

// ----- sv/lfu_frame_replacement_unit.sv -----
// ---------------------------------------------------------------------------
// LFU frame replacement unit
// Least-frequently-used page replacement with first-loaded tie break.
// ---------------------------------------------------------------------------
// A request is taken at a rising edge where start_i is high and busy_o is
// low; it carries page_number_i and last_of_string_i. The unit then walks
// the active frames one per cycle with a single compare unit: it looks for
// the first frame holding the page, the first empty frame, and the frame
// with the least use count (ties go to the earlier load stamp, then to the
// lower index). An update step then writes the frame tables. busy_o stays
// high from acceptance through the scan of the N active frames (N is the
// active frame count, 1 to 16) and the update, so each request is through
// before the next is taken; the frame walk through the single read port
// sets this busy time. The result is held on the result ports and marked by
// done_o for exactly one cycle, in the first cycle with busy_o low; a new
// request may be started in that same cycle. The receiver cannot stall
// the result. The frame count register is written through cfg_valid_i /
// cfg_ready_o while the unit is idle; the user must keep to this, the unit
// does not enforce it. Reset empties all frames, clears the access clock
// and the fault count, and sets the frame count to 16. A request marked
// last_of_string_i does the same clearing after its result is formed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lfu_frame_replacement_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Request channel
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [lfu_pkg::PAGE_BITS-1:0]         page_number_i,
  input  logic                                  last_of_string_i,
  // Result channel
  output logic                                  done_o,
  output logic                                  hit_o,
  output logic [lfu_pkg::PORT_SLOT_W-1:0]       frame_slot_o,
  output logic                                  evicted_o,
  output logic [lfu_pkg::PORT_PAGE_W-1:0]       evicted_page_o,
  output logic [lfu_pkg::FAULT_W-1:0]           fault_count_o,
  // Configuration channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [lfu_pkg::CFG_W-1:0]             cfg_frames_in_use_i
);

  localparam int unsigned SW = lfu_pkg::SLOT_W;
  localparam int unsigned PW = lfu_pkg::PAGE_BITS;
  localparam int unsigned CW = lfu_pkg::COUNT_W;
  localparam int unsigned TW = lfu_pkg::STAMP_W;
  localparam int unsigned FW = lfu_pkg::FAULT_W;

  // Sequencer.
  lfu_pkg::state_e state_q, state_d;
  logic            accept;
  logic            scan_en;
  logic            upd_en;
  logic            scan_last;

  // Configuration and string state.
  logic [lfu_pkg::CFG_W-1:0] frames_cfg_q;
  logic [lfu_pkg::CFG_W-1:0] frames_act;
  logic [SW-1:0]             last_idx;
  logic [lfu_pkg::FRAMES-1:0] slot_valid_q;
  logic [TW-1:0]             clock_q;
  logic [TW-1:0]             clock_next;
  logic [FW-1:0]             fault_q;
  logic [FW-1:0]             fault_next;

  // Latched request.
  logic [PW-1:0] page_q;
  logic          last_q;

  // Frame tables, one read port feeding the scan and one write port.
  logic [PW-1:0] page_mem  [lfu_pkg::FRAMES];
  logic [CW-1:0] count_mem [lfu_pkg::FRAMES];
  logic [TW-1:0] stamp_mem [lfu_pkg::FRAMES];
  logic [SW-1:0] rd_addr;
  logic [PW-1:0] rd_page_q;
  logic [CW-1:0] rd_count_q;
  logic [TW-1:0] rd_stamp_q;

  // Scan results.
  logic [SW-1:0] idx_q;
  logic          cur_valid;
  logic          found_hit_q;
  logic [SW-1:0] hit_slot_q;
  logic [CW-1:0] hit_count_q;
  logic          found_empty_q;
  logic [SW-1:0] empty_slot_q;
  logic [SW-1:0] best_slot_q;
  logic [CW-1:0] best_count_q;
  logic [TW-1:0] best_stamp_q;
  logic [PW-1:0] best_page_q;
  logic          take_best;

  // Update step.
  logic          fill_we;
  logic          count_we;
  logic [SW-1:0] wr_slot;
  logic [CW-1:0] wr_count;

  // Result registers.
  logic                            done_q;
  logic                            hit_q;
  logic [lfu_pkg::PORT_SLOT_W-1:0] slot_out_q;
  logic                            evicted_q;
  logic [lfu_pkg::PORT_PAGE_W-1:0] evicted_page_q;
  logic [FW-1:0]                   fault_out_q;

  // -------------------------------------------------------------------------
  // Sequencer: idle, a scan state that walks the active frames, then an update state.
  // -------------------------------------------------------------------------
  assign accept    = start_i && (state_q == lfu_pkg::ST_IDLE);
  assign scan_last = (idx_q == last_idx);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lfu_pkg::ST_IDLE: begin
        if (start_i) state_d = lfu_pkg::ST_SCAN;
      end
      lfu_pkg::ST_SCAN: begin
        if (scan_last) state_d = lfu_pkg::ST_UPDATE;
      end
      lfu_pkg::ST_UPDATE: begin
        state_d = lfu_pkg::ST_IDLE;
      end
      default: state_d = lfu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o  = 1'b1;
    scan_en = 1'b0;
    upd_en  = 1'b0;
    unique case (state_q)
      lfu_pkg::ST_IDLE:   busy_o  = 1'b0;
      lfu_pkg::ST_SCAN:   scan_en = 1'b1;
      lfu_pkg::ST_UPDATE: upd_en  = 1'b1;
      default:            busy_o  = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // -------------------------------------------------------------------------
  // Configuration. A count of zero acts as one frame, and anything above
  // the table size acts as the full table.
  // -------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_cfg_q <= lfu_pkg::CFG_FRAMES_RESET;
    end else if (cfg_valid_i) begin
      frames_cfg_q <= cfg_frames_in_use_i;
    end
  end

  always_comb begin
    frames_act = frames_cfg_q;
    if (frames_cfg_q == '0) frames_act = lfu_pkg::CFG_W'(1);
    if (frames_cfg_q > lfu_pkg::CFG_FRAMES_MAX) frames_act = lfu_pkg::CFG_FRAMES_MAX;
  end

  assign last_idx = SW'(frames_act - lfu_pkg::CFG_W'(1));

  // -------------------------------------------------------------------------
  // Frame tables. The read address runs one frame ahead of the scan index,
  // so the registered read data always belongs to the frame being scanned.
  // -------------------------------------------------------------------------
  assign rd_addr = (state_q == lfu_pkg::ST_IDLE) ? '0 : idx_q + SW'(1);

  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      page_mem[wr_slot]  <= page_q;
      stamp_mem[wr_slot] <= clock_next;
    end
    if (fill_we || count_we) begin
      count_mem[wr_slot] <= wr_count;
    end
    rd_page_q  <= page_mem[rd_addr];
    rd_count_q <= count_mem[rd_addr];
    rd_stamp_q <= stamp_mem[rd_addr];
  end

  // -------------------------------------------------------------------------
  // Scan: one frame per cycle through a single compare unit. The first
  // matching frame wins a hit, and the victim is replaced only on a strictly
  // smaller (count, stamp) pair, so equal pairs keep the lower index.
  // -------------------------------------------------------------------------
  assign cur_valid = slot_valid_q[idx_q];
  assign take_best = (idx_q == '0) ||
                     (rd_count_q < best_count_q) ||
                     ((rd_count_q == best_count_q) && (rd_stamp_q < best_stamp_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q         <= '0;
      found_hit_q   <= 1'b0;
      found_empty_q <= 1'b0;
    end else if (accept) begin
      idx_q         <= '0;
      found_hit_q   <= 1'b0;
      found_empty_q <= 1'b0;
    end else if (scan_en) begin
      idx_q <= idx_q + SW'(1);
      if (cur_valid && (rd_page_q == page_q) && !found_hit_q) begin
        found_hit_q <= 1'b1;
      end
      if (!cur_valid && !found_empty_q) begin
        found_empty_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q <= page_number_i;
      last_q <= last_of_string_i;
    end
    if (scan_en) begin
      if (cur_valid && (rd_page_q == page_q) && !found_hit_q) begin
        hit_slot_q  <= idx_q;
        hit_count_q <= rd_count_q;
      end
      if (!cur_valid && !found_empty_q) begin
        empty_slot_q <= idx_q;
      end
      if (take_best) begin
        best_slot_q  <= idx_q;
        best_count_q <= rd_count_q;
        best_stamp_q <= rd_stamp_q;
        best_page_q  <= rd_page_q;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Update: bump the hit frame's count, or load the page into the first
  // empty frame, or else into the victim. All counters saturate.
  // -------------------------------------------------------------------------
  assign clock_next = (clock_q == '1) ? clock_q : clock_q + TW'(1);
  assign fault_next = (fault_q == '1) ? fault_q : fault_q + FW'(1);

  always_comb begin
    fill_we  = 1'b0;
    count_we = 1'b0;
    wr_slot  = best_slot_q;
    wr_count = CW'(1);
    if (upd_en) begin
      if (found_hit_q) begin
        count_we = 1'b1;
        wr_slot  = hit_slot_q;
        wr_count = (hit_count_q == '1) ? hit_count_q : hit_count_q + CW'(1);
      end else begin
        fill_we = 1'b1;
        wr_slot = found_empty_q ? empty_slot_q : best_slot_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      clock_q      <= '0;
      fault_q      <= '0;
    end else if (upd_en) begin
      if (last_q) begin
        slot_valid_q <= '0;
        clock_q      <= '0;
        fault_q      <= '0;
      end else begin
        clock_q <= clock_next;
        if (fill_we) begin
          slot_valid_q[wr_slot] <= 1'b1;
          fault_q               <= fault_next;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result registers, loaded by the update; done_o is high for one cycle after it.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= upd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_en) begin
      hit_q       <= found_hit_q;
      slot_out_q  <= lfu_pkg::PORT_SLOT_W'(wr_slot);
      evicted_q   <= !found_hit_q && !found_empty_q;
      fault_out_q <= found_hit_q ? fault_q : fault_next;
      if (!found_hit_q && !found_empty_q) begin
        evicted_page_q <= lfu_pkg::PORT_PAGE_W'(best_page_q);
      end else begin
        evicted_page_q <= '0;
      end
    end
  end

  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign frame_slot_o   = slot_out_q;
  assign evicted_o      = evicted_q;
  assign evicted_page_o = evicted_page_q;
  assign fault_count_o  = fault_out_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `ASSERT_PROP(a_done_after_update, clk_i, rst_ni, upd_en |=> done_q, "result strobe missing after update")
  `ASSERT_PROP(a_done_when_idle, clk_i, rst_ni, done_q |-> !busy_o, "result shown while busy")
  `ASSERT_NEVER(a_hit_and_evict, clk_i, rst_ni, done_q && hit_q && evicted_q, "hit reported as eviction")
  `ASSERT_PROP(a_evict_page_zero, clk_i, rst_ni, (done_q && !evicted_q) |-> (evicted_page_q == '0), "evicted page not zero")
  `ASSERT_PROP(a_scan_in_range, clk_i, rst_ni, scan_en |-> (idx_q <= last_idx), "scan beyond active frames")

endmodule

// ----- tb/sv/lfu_frame_replacement_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// LFU frame replacement checker
// Watches the request, configuration and result channels of the replacement
// unit. It keeps its own frame table and predicts each result, then compares
// every result field with the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module lfu_frame_replacement_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic [lfu_pkg::PAGE_BITS-1:0]   page_number_i,
  input  logic                            last_of_string_i,
  input  logic                            done_i,
  input  logic                            hit_i,
  input  logic [lfu_pkg::PORT_SLOT_W-1:0] frame_slot_i,
  input  logic                            evicted_i,
  input  logic [lfu_pkg::PORT_PAGE_W-1:0] evicted_page_i,
  input  logic [lfu_pkg::FAULT_W-1:0]     fault_count_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [lfu_pkg::CFG_W-1:0]       cfg_frames_in_use_i,
  output int                              pending_o,
  output int                              mismatches_o,
  output int                              hits_o,
  output int                              evictions_o,
  output int                              checked_o
);

  typedef struct packed {
    logic                            hit;
    logic [lfu_pkg::PORT_SLOT_W-1:0] frame_slot;
    logic                            evicted;
    logic [lfu_pkg::PORT_PAGE_W-1:0] evicted_page;
    logic [lfu_pkg::FAULT_W-1:0]     fault_count;
  } frame_verdict_t;

  // Shadow frame table.
  logic [lfu_pkg::PAGE_BITS-1:0] frame_page  [lfu_pkg::FRAMES];
  bit                            frame_valid [lfu_pkg::FRAMES];
  logic [lfu_pkg::COUNT_W-1:0]   frame_uses  [lfu_pkg::FRAMES];
  logic [lfu_pkg::STAMP_W-1:0]   frame_stamp [lfu_pkg::FRAMES];
  logic [lfu_pkg::STAMP_W-1:0]   access_clock;
  logic [lfu_pkg::FAULT_W-1:0]   fault_total;
  logic [lfu_pkg::CFG_W-1:0]     frame_limit;

  frame_verdict_t awaited_verdicts[$];
  frame_verdict_t want;
  frame_verdict_t got;

  int mismatches;
  int hits;
  int evictions;
  int checked;

  assign pending_o    = awaited_verdicts.size();
  assign mismatches_o = mismatches;
  assign hits_o       = hits;
  assign evictions_o  = evictions;
  assign checked_o    = checked;

  // Works out the result of one page reference and updates the shadow table.
  function automatic frame_verdict_t lfu_lookup(logic [lfu_pkg::PAGE_BITS-1:0] page,
                                                logic last);
    int unsigned    n;
    int unsigned    slot;
    bit             found;
    bit             empty;
    frame_verdict_t r;
    n     = frame_limit;
    if (n < 1) n = 1;
    if (n > lfu_pkg::FRAMES) n = lfu_pkg::FRAMES;
    r     = '0;
    slot  = 0;
    found = 1'b0;
    empty = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (frame_valid[i] && frame_page[i] == page) begin
        found = 1'b1;
        slot  = i;
        break;
      end
    end
    if (access_clock != '1) access_clock++;
    if (found) begin
      if (frame_uses[slot] != '1) frame_uses[slot]++;
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        if (!frame_valid[i]) begin
          empty = 1'b1;
          slot  = i;
          break;
        end
      end
      if (!empty) begin
        // Least use count wins; a tie goes to the earlier load, then the lower index.
        slot = 0;
        for (int unsigned i = 1; i < n; i++) begin
          if (frame_uses[i] < frame_uses[slot] ||
              (frame_uses[i] == frame_uses[slot] && frame_stamp[i] < frame_stamp[slot]))
            slot = i;
        end
        r.evicted      = 1'b1;
        r.evicted_page = frame_page[slot];
      end
      frame_page[slot]  = page;
      frame_valid[slot] = 1'b1;
      frame_uses[slot]  = lfu_pkg::COUNT_W'(1);
      frame_stamp[slot] = access_clock;
      if (fault_total != '1) fault_total++;
    end
    r.hit         = found;
    r.frame_slot  = slot[lfu_pkg::PORT_SLOT_W-1:0];
    r.fault_count = fault_total;
    if (last) begin
      foreach (frame_valid[i]) frame_valid[i] = 1'b0;
      access_clock = '0;
      fault_total  = '0;
    end
    return r;
  endfunction

  task automatic flag_field(string field, longint unsigned exp, longint unsigned act);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: %s expected %0h, got %0h", $time, field, exp, act);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (frame_valid[i]) begin
        frame_valid[i] = 1'b0;
        frame_page[i]  = '0;
        frame_uses[i]  = '0;
        frame_stamp[i] = '0;
      end
      access_clock = '0;
      fault_total  = '0;
      frame_limit  = lfu_pkg::CFG_FRAMES_RESET;
      awaited_verdicts.delete();
    end else begin
      // The result is retired before a request taken at the same edge is predicted.
      if (done_i) begin
        got = '{hit_i, frame_slot_i, evicted_i, evicted_page_i, fault_count_i};
        if (awaited_verdicts.size() == 0) begin
          flag_field("result with no request waiting, fields", '0, got);
        end else begin
          want = awaited_verdicts.pop_front();
          checked++;
          if (want.hit) hits++;
          if (want.evicted) evictions++;
          if (got.hit !== want.hit) flag_field("hit", want.hit, got.hit);
          if (got.frame_slot !== want.frame_slot)
            flag_field("frame_slot", want.frame_slot, got.frame_slot);
          if (got.evicted !== want.evicted) flag_field("evicted", want.evicted, got.evicted);
          if (got.evicted_page !== want.evicted_page)
            flag_field("evicted_page", want.evicted_page, got.evicted_page);
          if (got.fault_count !== want.fault_count)
            flag_field("fault_count", want.fault_count, got.fault_count);
        end
      end
      if (cfg_valid_i && cfg_ready_i) frame_limit = cfg_frames_in_use_i;
      if (start_i && !busy_i)
        awaited_verdicts.push_back(lfu_lookup(page_number_i, last_of_string_i));
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// LFU frame replacement unit testbench
// Drives page references and frame-count writes into the replacement unit
// and leaves all prediction and comparison to the checker beside it.
// ---------------------------------------------------------------------------
// The run has two parts. A short directed part walks the obvious corners:
// the extreme page numbers, hits, fills, eviction by least count and by the
// earlier load on a tie, the end-of-string clear, frame counts of zero and
// above the table size, and frames that drop out of the active range and
// come back with their pages intact.
// The random part runs through a series of frame-count settings. Most pages
// come from a small skewed pool per setting so that hits, ties and
// evictions are common; the rest are fully random page numbers.
// Requests are presented at the falling clock edge and held until the unit
// takes them. The gap before each request is random, mostly zero, sometimes
// short and now and then long; some settings run without gaps at all.
// The frame count is written only once every request has been answered.
// ---------------------------------------------------------------------------
module testbench;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start_i;
  logic                            busy_o;
  logic [lfu_pkg::PAGE_BITS-1:0]   page_number_i;
  logic                            last_of_string_i;
  logic                            done_o;
  logic                            hit_o;
  logic [lfu_pkg::PORT_SLOT_W-1:0] frame_slot_o;
  logic                            evicted_o;
  logic [lfu_pkg::PORT_PAGE_W-1:0] evicted_page_o;
  logic [lfu_pkg::FAULT_W-1:0]     fault_count_o;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [lfu_pkg::CFG_W-1:0]       cfg_frames_in_use_i;

  int pending;
  int mismatches;
  int hits;
  int evictions;
  int checked;

  // Stimulus bookkeeping: active frame count and the page pool of a setting.
  int unsigned                   active_n;
  int unsigned                   settings_seen;
  logic [lfu_pkg::PAGE_BITS-1:0] page_pool [24];
  int unsigned                   pool_n;
  bit                            quiet_phase;

  lfu_frame_replacement_unit i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .page_number_i       (page_number_i),
    .last_of_string_i    (last_of_string_i),
    .done_o              (done_o),
    .hit_o               (hit_o),
    .frame_slot_o        (frame_slot_o),
    .evicted_o           (evicted_o),
    .evicted_page_o      (evicted_page_o),
    .fault_count_o       (fault_count_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_frames_in_use_i (cfg_frames_in_use_i)
  );

  lfu_frame_replacement_checker i_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_i              (busy_o),
    .page_number_i       (page_number_i),
    .last_of_string_i    (last_of_string_i),
    .done_i              (done_o),
    .hit_i               (hit_o),
    .frame_slot_i        (frame_slot_o),
    .evicted_i           (evicted_o),
    .evicted_page_i      (evicted_page_o),
    .fault_count_i       (fault_count_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_i         (cfg_ready_o),
    .cfg_frames_in_use_i (cfg_frames_in_use_i),
    .pending_o           (pending),
    .mismatches_o        (mismatches),
    .hits_o              (hits),
    .evictions_o         (evictions),
    .checked_o           (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Even with every gap at its longest a correct run ends well before this timeout.
  initial begin
    #500000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Gap before a request: mostly none, often shorter than the unit's busy
  // time so that it lands inside the frame walk, and now and then long.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (quiet_phase || r < 55) return 0;
    if (r < 93) return $urandom_range(active_n + 4, 1);
    return $urandom_range(60, 20);
  endfunction

  // Presents one request after the given gap and returns at the falling
  // edge after the unit has taken it. The start line stays high unless the
  // next call opens a gap, so back-to-back requests keep it raised.
  task automatic issue_ref(logic [lfu_pkg::PAGE_BITS-1:0] page, logic last,
                           int unsigned gap);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i          = 1'b1;
    page_number_i    = page;
    last_of_string_i = last;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Writes the frame count once every outstanding request has been answered.
  task automatic write_frames(logic [lfu_pkg::CFG_W-1:0] value);
    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_valid_i         = 1'b1;
    cfg_frames_in_use_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    active_n    = (value == 0) ? 1 : (value > lfu_pkg::FRAMES) ? lfu_pkg::FRAMES : value;
    settings_seen++;
  endtask

  initial begin
    rst_ni              = 1'b0;
    start_i             = 1'b0;
    page_number_i       = '0;
    last_of_string_i    = 1'b0;
    cfg_valid_i         = 1'b0;
    cfg_frames_in_use_i = '0;
    active_n            = lfu_pkg::FRAMES;
    settings_seen       = 1;
    quiet_phase         = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset frame count: fills at both page extremes, a hit, then an
    // end-of-string mark. The reference after it must start from an empty table.
    issue_ref(16'h0000, 1'b0, 0);
    issue_ref(16'hFFFF, 1'b0, 1);
    issue_ref(16'h0000, 1'b0, 0);
    issue_ref(16'hAAAA, 1'b0, 3);
    issue_ref(16'h5555, 1'b1, 0);
    issue_ref(16'h0000, 1'b0, 0);

    // A count of zero behaves as one frame: every new page evicts slot 0.
    write_frames(5'd0);
    issue_ref(16'h1234, 1'b0, 0);
    issue_ref(16'h1234, 1'b0, 0);
    issue_ref(16'h4321, 1'b0, 2);

    // Three frames: fill two, then a miss among equal counts evicts the
    // earliest load. After a hit raises one count, a tie between the other
    // two again goes to the earlier load.
    write_frames(5'd3);
    issue_ref(16'hBEEF, 1'b0, 0);
    issue_ref(16'hCAFE, 1'b0, 0);
    issue_ref(16'h0F0F, 1'b0, 0);
    issue_ref(16'hBEEF, 1'b0, 0);
    issue_ref(16'h1111, 1'b0, 0);

    // A count above the table size acts as the full table; the page lands
    // in slot 3. With two frames active that slot is ignored, so the same
    // page misses. Raising the count again brings slot 3 back.
    write_frames(5'd31);
    issue_ref(16'h7777, 1'b0, 0);
    write_frames(5'd2);
    issue_ref(16'h7777, 1'b0, 0);
    write_frames(5'd16);
    issue_ref(16'h7777, 1'b0, 0);
    issue_ref(16'h1111, 1'b1, 0);

    // Random part: each setting gets its own skewed page pool, slightly
    // larger than the active frame count so that evictions keep happening.
    for (int unsigned ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       write_frames(5'd16);
        1:       write_frames(5'd1);
        2:       write_frames(5'd8);
        3:       write_frames(5'd31);
        4:       write_frames(5'd0);
        5:       write_frames(5'd5);
        6:       write_frames(5'd12);
        default: write_frames(lfu_pkg::CFG_W'($urandom_range(31)));
      endcase
      quiet_phase = ($urandom_range(3) == 0);
      pool_n      = active_n + $urandom_range(6, 1);
      if (pool_n > 24) pool_n = 24;
      foreach (page_pool[k]) page_pool[k] = lfu_pkg::PAGE_BITS'($urandom);
      repeat (75) begin
        issue_ref(($urandom_range(99) < 80)
                    ? page_pool[$urandom_range($urandom_range(pool_n - 1))]
                    : lfu_pkg::PAGE_BITS'($urandom),
                  ($urandom_range(59) == 0), draw_gap());
      end
    end

    // Drain: every result must arrive, then a quiet stretch catches strays.
    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    $display("Checked %0d references: %0d hits, %0d evictions, over %0d frame-count settings,",
             checked, hits, evictions, settings_seen);
    $display("including tie-broken evictions, inactive frames and end-of-string clears.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
